// ===== rtl/sliding_mode_position_controller_top_defines.svh =====
// Assertion macros for the sliding-mode position controller.
// Used by the top level only; no other dependencies.
`ifndef SLIDING_MODE_POSITION_CONTROLLER_TOP_DEFINES_SVH
`define SLIDING_MODE_POSITION_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SMPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/smpc_pkg.sv =====
// Shared types and constants for the sliding-mode position controller.
// No dependencies.
package smpc_pkg;
    localparam int FRAC_BITS = 16;
    localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] ALPHA_Q = 34'((((64'd85) << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [33:0] BETA_Q = ONE_Q - ALPHA_Q;
    localparam logic [15:0] DEFAULT_RATE = 16'd1000;
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_SLOPE = 3'd0;
    localparam logic [2:0] REG_REACH = 3'd1;
    localparam logic [2:0] REG_SWITCH = 3'd2;
    localparam logic [2:0] REG_DEADBAND = 3'd3;
    localparam logic [2:0] REG_LIMIT = 3'd4;
    localparam logic [2:0] REG_INERTIA = 3'd5;
    localparam logic [2:0] REG_BOUNDARY = 3'd6;
    localparam logic [2:0] REG_TICK = 3'd7;

    // Datapath step codes issued by the controller.
    typedef enum logic [4:0] {
        OP_DIFF  = 5'd0,  // error, target delta
        OP_RATE  = 5'd1,  // rate = sat(delta*tick)
        OP_ACC   = 5'd2,  // rate - previous rate, deadband test
        OP_ACCM  = 5'd3,  // (rate - previous rate)*tick
        OP_VERR  = 5'd4,  // accel, verr, C*error
        OP_SURF  = 5'd5,  // s, C*verr
        OP_KS    = 5'd6,  // K*s, start boundary division
        OP_DIVST = 5'd7,  // one quotient bit
        OP_BSAT  = 5'd8,  // subtract K*s, eps*sat
        OP_INNER = 5'd9,  // inner sum
        OP_RAW   = 5'd10, // J*inner
        OP_CLAMP = 5'd11, // clamp, alpha*prev
        OP_FILT  = 5'd12, // beta*raw
        OP_DONE  = 5'd13  // drive, publish
    } op_t;

    typedef struct packed {
        logic start;
        logic step;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [30:0] slope;
        logic [30:0] reach;
        logic [30:0] switch_g;
        logic [30:0] deadband;
        logic [30:0] limit;
        logic signed [31:0] inertia;
        logic signed [31:0] boundary;
        logic [15:0] tick;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (x < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else r = x[31:0];
        return r;
    endfunction
endpackage

// ===== rtl/sliding_mode_position_controller_top.sv =====
// Sliding-mode position controller: a transaction on the input channel is one
// control tick and yields exactly one result. The next input can be accepted
// in the same cycle that a tick's result becomes valid. A tick runs twelve
// sequenced steps on a shared 34x34 multiplier plus a divider pass (32 radix-2
// quotient steps and one step to form the boundary-layer ratio). Ticks inside
// the deadband skip the law and go from the deadband test straight to the
// final step.
// The final step of a tick also waits while the previous result is unread.
// Configuration must be written over the APB port (register i at byte address
// 4*i) only while the block is idle; the block itself does not enforce this.
// Depends on smpc_pkg, smpc_ctrl, smpc_dp and the defines header.
`include "sliding_mode_position_controller_top_defines.svh"
module sliding_mode_position_controller_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            measured_angle,
    input  logic signed [31:0]            angular_velocity,
    input  logic signed [31:0]            target_angle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            drive,
    output logic signed [31:0]            sliding_surface,
    output logic                          in_deadband
);
    smpc_pkg::cfg_t cfg_reg;
    smpc_pkg::dp_cmd_t cmd;
    smpc_pkg::dp_status_t status;
    logic busy;
    logic publish;
    logic in_fire;
    logic out_valid_reg;
    logic [2:0] ridx;
    logic signed [31:0] drive_val;
    logic signed [31:0] surface_val;
    logic dead_val;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign in_ready = !busy;
    assign in_fire = in_valid && in_ready;

    // The result register holds the last transaction until it is taken; a new
    // tick may start meanwhile and only waits at its final step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end
    assign out_valid = out_valid_reg;
    assign drive = drive_val;
    assign sliding_surface = surface_val;
    assign in_deadband = dead_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope <= '0;
            cfg_reg.reach <= '0;
            cfg_reg.switch_g <= '0;
            cfg_reg.deadband <= '0;
            cfg_reg.limit <= 31'(smpc_pkg::ONE_Q);
            cfg_reg.inertia <= 32'(smpc_pkg::ONE_Q);
            cfg_reg.boundary <= '0;
            cfg_reg.tick <= smpc_pkg::DEFAULT_RATE;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                smpc_pkg::REG_SLOPE:    cfg_reg.slope <= pwdata[30:0];
                smpc_pkg::REG_REACH:    cfg_reg.reach <= pwdata[30:0];
                smpc_pkg::REG_SWITCH:   cfg_reg.switch_g <= pwdata[30:0];
                smpc_pkg::REG_DEADBAND: cfg_reg.deadband <= pwdata[30:0];
                smpc_pkg::REG_LIMIT:    cfg_reg.limit <= pwdata[30:0];
                smpc_pkg::REG_INERTIA:  cfg_reg.inertia <= pwdata;
                smpc_pkg::REG_BOUNDARY: cfg_reg.boundary <= pwdata;
                smpc_pkg::REG_TICK:     cfg_reg.tick <= pwdata[15:0];
                default:                cfg_reg.tick <= cfg_reg.tick;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            smpc_pkg::REG_SLOPE:    prdata = {1'b0, cfg_reg.slope};
            smpc_pkg::REG_REACH:    prdata = {1'b0, cfg_reg.reach};
            smpc_pkg::REG_SWITCH:   prdata = {1'b0, cfg_reg.switch_g};
            smpc_pkg::REG_DEADBAND: prdata = {1'b0, cfg_reg.deadband};
            smpc_pkg::REG_LIMIT:    prdata = {1'b0, cfg_reg.limit};
            smpc_pkg::REG_INERTIA:  prdata = cfg_reg.inertia;
            smpc_pkg::REG_BOUNDARY: prdata = cfg_reg.boundary;
            smpc_pkg::REG_TICK:     prdata = {16'd0, cfg_reg.tick};
            default:                prdata = '0;
        endcase
    end

    smpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (!out_valid_reg || out_ready),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .publish  (publish)
    );

    smpc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .measured_angle   (measured_angle),
        .angular_velocity (angular_velocity),
        .target_angle     (target_angle),
        .status           (status),
        .drive_val        (drive_val),
        .surface_val      (surface_val),
        .dead_val         (dead_val)
    );

    // No new tick starts while one is in progress.
    `SMPC_ASSERT_NEXT(a_no_start_busy, clk, rst_n, in_fire, busy)
    // A result is published only when the output register can take it.
    `SMPC_ASSERT_NEXT(a_pub_valid, clk, rst_n, publish, out_valid)
    // A waiting result stays until taken.
    `SMPC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

// ===== rtl/smpc_ctrl.sv =====
// Sequencer for the sliding-mode position controller.
// Depends on smpc_pkg.
module smpc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic                   out_free,
    input  smpc_pkg::dp_status_t   status,
    output smpc_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   publish
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    smpc_pkg::op_t op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd.start = 1'b0;
        cmd.step = 1'b0;
        cmd.op = op_reg;
        publish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start = 1'b1;
                    state_next = S_RUN;
                    op_next = smpc_pkg::OP_RATE;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                case (op_reg)
                    smpc_pkg::OP_ACC:
                        op_next = smpc_pkg::OP_ACCM;
                    smpc_pkg::OP_KS:
                    begin
                        op_next = smpc_pkg::OP_DIVST;
                        state_next = S_DIV;
                    end
                    smpc_pkg::OP_DONE:
                    begin
                        if (out_free)
                        begin
                            publish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.step = 1'b0;
                        end
                    end
                    default:
                        op_next = smpc_pkg::op_t'(op_reg + 5'd1);
                endcase
                if (op_reg == smpc_pkg::OP_ACC && status.dead)
                    op_next = smpc_pkg::OP_DONE;
            end
            S_DIV:
            begin
                // The last divider cycle also steps, so the datapath forms sat(s).
                cmd.step = 1'b1;
                if (status.div_done)
                begin
                    op_next = smpc_pkg::OP_BSAT;
                    state_next = S_RUN;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= smpc_pkg::OP_DIFF;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end
endmodule

// ===== rtl/smpc_dp.sv =====
// Datapath of the sliding-mode position controller: one shared multiplier,
// an adder stage and a radix-2 divider. Depends on smpc_pkg.
module smpc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smpc_pkg::cfg_t       cfg,
    input  smpc_pkg::dp_cmd_t    cmd,
    input  logic signed [31:0]   measured_angle,
    input  logic signed [31:0]   angular_velocity,
    input  logic signed [31:0]   target_angle,
    output smpc_pkg::dp_status_t status,
    output logic signed [31:0]   drive_val,
    output logic signed [31:0]   surface_val,
    output logic                 dead_val
);
    localparam int FB = smpc_pkg::FRAC_BITS;

    logic signed [31:0] vel_reg, tgt_reg;
    logic signed [31:0] err_reg, rate_reg, acc_reg, verr_reg, s_reg;
    logic signed [32:0] delta_reg;
    logic signed [31:0] ptgt_reg, trate_reg, pdrv_reg;
    logic signed [65:0] acc0_reg;   // running inner sum / scratch
    logic signed [65:0] prod_reg;   // registered multiplier output
    logic signed [33:0] bsat_reg;
    logic signed [31:0] raw_reg;
    logic               dead_reg;
    // divider
    logic [47:0] rem_reg;
    logic [47:0] num_reg;
    logic [31:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;
    logic        dclip_reg;

    logic [15:0] tick_eff;
    logic signed [32:0] jq;
    logic signed [31:0] lim;
    logic signed [33:0] ma;
    logic signed [33:0] mb;
    logic signed [67:0] mprod;
    logic signed [65:0] mulq_res;
    logic signed [32:0] abs_err;
    logic signed [32:0] abs_s;
    logic [47:0] rem_sh;
    logic [31:0] bw_mag;

    assign tick_eff = (cfg.tick == 16'd0) ? smpc_pkg::DEFAULT_RATE : cfg.tick;
    assign jq = (cfg.inertia == 32'sd0) ? 33'(smpc_pkg::ONE_Q) : 33'(cfg.inertia);
    assign lim = (cfg.limit == 31'd0) ? 32'(smpc_pkg::ONE_Q) : {1'b0, cfg.limit};
    assign abs_err = err_reg[31] ? -33'(err_reg) : 33'(err_reg);
    assign abs_s = s_reg[31] ? -33'(s_reg) : 33'(s_reg);
    assign bw_mag = cfg.boundary;

    // Operand select for the shared multiplier, by step.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            smpc_pkg::OP_RATE:  begin ma = 34'(delta_reg); mb = 34'({1'b0, tick_eff}); end
            smpc_pkg::OP_ACCM:
            begin
                ma = 34'(signed'(acc0_reg[32:0]));
                mb = 34'({1'b0, tick_eff});
            end
            smpc_pkg::OP_VERR:  begin ma = 34'({1'b0, cfg.slope}); mb = 34'(err_reg); end
            smpc_pkg::OP_SURF:  begin ma = 34'({1'b0, cfg.slope}); mb = 34'(verr_reg); end
            smpc_pkg::OP_KS:    begin ma = 34'({1'b0, cfg.reach}); mb = 34'(s_reg); end
            smpc_pkg::OP_BSAT:  begin ma = 34'({1'b0, cfg.switch_g}); mb = bsat_reg; end
            smpc_pkg::OP_RAW:   begin ma = 34'(jq); mb = 34'(signed'(acc0_reg[31:0])); end
            smpc_pkg::OP_CLAMP: begin ma = smpc_pkg::ALPHA_Q; mb = 34'(pdrv_reg); end
            smpc_pkg::OP_FILT:  begin ma = smpc_pkg::BETA_Q; mb = 34'(raw_reg); end
            default:            begin ma = '0; mb = '0; end
        endcase
    end

    assign mprod = ma * mb;
    assign mulq_res = prod_reg >>> FB;
    assign rem_sh = {rem_reg[46:0], num_reg[47]};

    assign status.dead = (abs_err < 33'({1'b0, cfg.deadband}));
    assign status.div_done = (dcnt_reg == 6'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            vel_reg <= angular_velocity;
            tgt_reg <= target_angle;
            err_reg <= smpc_pkg::sat32(66'(measured_angle) - 66'(target_angle));
            delta_reg <= 33'(target_angle) - 33'(ptgt_reg);
        end
        else if (cmd.step)
        begin
            // K*s stays in the product register while the divider runs.
            if (cmd.op != smpc_pkg::OP_DIVST)
                prod_reg <= 66'(mprod);
            case (cmd.op)
                smpc_pkg::OP_ACC:
                begin
                    // prod holds delta*tick from the previous step
                    rate_reg <= smpc_pkg::sat32(prod_reg);
                    acc0_reg <= 66'(smpc_pkg::sat32(prod_reg)) - 66'(trate_reg);
                end
                smpc_pkg::OP_VERR:
                begin
                    acc_reg <= smpc_pkg::sat32(prod_reg);
                    verr_reg <= smpc_pkg::sat32(66'(vel_reg) - 66'(rate_reg));
                end
                smpc_pkg::OP_SURF:
                    s_reg <= smpc_pkg::sat32(mulq_res + 66'(verr_reg));
                smpc_pkg::OP_KS:
                begin
                    acc0_reg <= 66'(acc_reg) - mulq_res;
                    // boundary division setup, |s|*ONE / width
                    quo_reg <= '0;
                    dcnt_reg <= 6'd48 - 6'd16;
                    dneg_reg <= s_reg[31];
                    dclip_reg <= (cfg.boundary <= 32'sd0) || (abs_s > 33'(cfg.boundary));
                    num_reg <= (48'(abs_s) << FB) << 16;
                    rem_reg <= 48'(abs_s) >> 16;
                end
                smpc_pkg::OP_DIVST:
                begin
                    if (dcnt_reg != 6'd0)
                    begin
                        num_reg <= num_reg << 1;
                        if (rem_sh >= 48'(bw_mag))
                        begin
                            rem_reg <= rem_sh - 48'(bw_mag);
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 6'd1;
                    end
                end
                smpc_pkg::OP_BSAT:
                    acc0_reg <= acc0_reg - mulq_res;
                smpc_pkg::OP_INNER:
                    acc0_reg <= 66'(smpc_pkg::sat32(acc0_reg - mulq_res));
                smpc_pkg::OP_CLAMP:
                begin
                    if (mulq_res > 66'(lim)) raw_reg <= lim;
                    else if (mulq_res < -66'(lim)) raw_reg <= -lim;
                    else raw_reg <= mulq_res[31:0];
                end
                smpc_pkg::OP_FILT:
                    acc0_reg <= prod_reg;
                default:
                    acc0_reg <= acc0_reg;
            endcase
            if (cmd.op == smpc_pkg::OP_ACC)
                dead_reg <= status.dead;
        end
    end

    // Boundary saturation result, formed once the divider finishes.
    always_ff @(posedge clk)
    begin
        if (cmd.step && cmd.op == smpc_pkg::OP_DIVST && dcnt_reg == 6'd0)
        begin
            if (dclip_reg)
            begin
                if (s_reg == 32'sd0) bsat_reg <= '0;
                else bsat_reg <= dneg_reg ? -smpc_pkg::ONE_Q : smpc_pkg::ONE_Q;
            end
            else
                bsat_reg <= dneg_reg ? -34'({2'b00, quo_reg}) : 34'({2'b00, quo_reg});
        end
    end

    // Outputs of the finished transaction and the state carried to the next tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_val <= '0;
            surface_val <= '0;
            dead_val <= 1'b0;
            ptgt_reg <= '0;
            trate_reg <= '0;
            pdrv_reg <= '0;
        end
        else if (cmd.step && cmd.op == smpc_pkg::OP_DONE)
        begin
            dead_val <= dead_reg;
            surface_val <= dead_reg ? 32'sd0 : s_reg;
            drive_val <= dead_reg ? 32'sd0 : smpc_pkg::sat32((acc0_reg + prod_reg) >>> FB);
            ptgt_reg <= tgt_reg;
            if (dead_reg)
            begin
                pdrv_reg <= '0;
                trate_reg <= '0;
            end
            else
            begin
                pdrv_reg <= smpc_pkg::sat32((acc0_reg + prod_reg) >>> FB);
                trate_reg <= rate_reg;
            end
        end
    end
endmodule
